/* rtl/core/dis_pkg.sv */
// ----------------------------------------------------------------------------
// dis_pkg
// Shared types and codes for the disjoint interval set block.
// ----------------------------------------------------------------------------
package dis_pkg;

  // table size and coordinate width
  localparam int CAPACITY   = 16;
  localparam int COORD_BITS = 32;

  localparam logic [1:0] OP_ADD       = 2'd0;
  localparam logic [1:0] OP_REMOVE    = 2'd1;
  localparam logic [1:0] OP_CONTAINS  = 2'd2;
  localparam logic [1:0] OP_INTERSECT = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic load;     // capture the incoming beat
    logic scan;     // process one table entry
    logic finish;   // tail of the walk: place pending add range
    logic commit;   // copy work table to main table (one entry per cycle)
    logic done;     // latch result fields
  } dis_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_last;
    logic copy_last;
    logic changes;  // op modifies the table and the range is not empty
    logic fits;     // work table fits capacity
  } dis_sts_t;

endpackage

/* rtl/core/dis_ctrl.sv */
// ----------------------------------------------------------------------------
// dis_ctrl
// Sequencer for the entry walk, commit copy and result hand-off.
// ----------------------------------------------------------------------------
module dis_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              out_fire,
  input  dis_pkg::dis_sts_t sts,
  output dis_pkg::dis_cmd_t cmd,
  output logic              idle,
  output logic              out_busy
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_FINISH = 6'b000100,
    S_COPY   = 6'b001000,
    S_DONE   = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = (sts.changes && sts.fits) ? S_COPY : S_DONE;
      end
      S_COPY: begin
        cmd.commit = 1'b1;
        if (sts.copy_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.done  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign idle     = (state_r == S_IDLE);
  assign out_busy = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

/* rtl/core/dis_dp.sv */
// ----------------------------------------------------------------------------
// dis_dp
// Interval table, work table and per-entry scan arithmetic.
// ----------------------------------------------------------------------------
module dis_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  dis_pkg::dis_cmd_t cmd,
  output dis_pkg::dis_sts_t sts,
  input  logic [1:0]        in_operation,
  input  logic [31:0]       in_left,
  input  logic [32:0]       in_right,
  output logic              res_hit,
  output logic [32:0]       res_total,
  output logic [32:0]       res_max,
  output logic [4:0]        res_count,
  output logic              res_ovf
);

  localparam int CAPACITY   = dis_pkg::CAPACITY;
  localparam int COORD_BITS = dis_pkg::COORD_BITS;
  localparam int CW = COORD_BITS + 1;
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NW = $clog2(CAPACITY + 3);
  localparam logic [CW-1:0] LIMIT = CW'(1) << COORD_BITS;

  // main table and work table
  logic [CW-1:0] st_mem [CAPACITY];
  logic [CW-1:0] en_mem [CAPACITY];
  logic [CW-1:0] ws_mem [CAPACITY];
  logic [CW-1:0] we_mem [CAPACITY];

  logic [NW-1:0] count_r;
  logic [CW-1:0] sum_r;

  logic [1:0]    op_r;
  logic [CW-1:0] l_r, r_r, ml_r, mr_r;
  logic [NW-1:0] idx_r, n_r;
  logic          placed_r, hit_r, ovf_r;
  logic [CW-1:0] max_r, wsum_r, wmax_r;

  logic [CW-1:0] l_in, r_in;
  always_comb begin
    l_in = {1'b0, in_left};
    r_in = (in_right > LIMIT) ? LIMIT : in_right;
  end

  // current entry
  logic          in_table;
  logic [CW-1:0] a, b, len;
  logic          empty_rng, chg;
  assign in_table  = ({1'b0, idx_r} < {1'b0, count_r}) && (idx_r < NW'(CAPACITY));
  assign a         = st_mem[idx_r[IW-1:0]];
  assign b         = en_mem[idx_r[IW-1:0]];
  assign len       = b - a;
  assign empty_rng = !(l_r < r_r);
  assign chg       = !empty_rng && (op_r == dis_pkg::OP_ADD || op_r == dis_pkg::OP_REMOVE);

  // push up to two entries into the work table in one cycle
  logic          p0, p1;
  logic [CW-1:0] p0s, p0e, p1s, p1e;
  logic [CW-1:0] ml_nxt, mr_nxt;
  logic          placed_nxt;
  always_comb begin
    p0 = 1'b0; p1 = 1'b0;
    p0s = a; p0e = b; p1s = a; p1e = b;
    ml_nxt = ml_r; mr_nxt = mr_r; placed_nxt = placed_r;
    if (cmd.scan && in_table && chg) begin
      if (op_r == dis_pkg::OP_ADD) begin
        if (b < l_r) begin
          p0 = 1'b1;
        end else if (a > r_r) begin
          if (!placed_r) begin
            p0 = 1'b1; p0s = ml_r; p0e = mr_r; p1 = 1'b1; placed_nxt = 1'b1;
          end else begin
            p0 = 1'b1;
          end
        end else begin
          if (a < ml_r) ml_nxt = a;
          if (b > mr_r) mr_nxt = b;
        end
      end else begin
        if (b <= l_r || a >= r_r) begin
          p0 = 1'b1;
        end else begin
          if (a < l_r) begin
            p0 = 1'b1; p0e = l_r;
            if (b > r_r) begin p1 = 1'b1; p1s = r_r; end
          end else if (b > r_r) begin
            p0 = 1'b1; p0s = r_r;
          end
        end
      end
    end else if (cmd.finish && chg && op_r == dis_pkg::OP_ADD && !placed_r) begin
      p0 = 1'b1; p0s = ml_r; p0e = mr_r;
    end
  end

  // longest entry pushed so far, including this cycle's pushes
  logic [CW-1:0] p0len, p1len, wmax_nxt;
  always_comb begin
    p0len    = p0e - p0s;
    p1len    = p1e - p1s;
    wmax_nxt = wmax_r;
    if (p0 && p0len > wmax_nxt) wmax_nxt = p0len;
    if (p1 && p1len > wmax_nxt) wmax_nxt = p1len;
  end

  assign sts.scan_last = (idx_r >= NW'(CAPACITY - 1)) || !in_table ||
                         ({1'b0, idx_r} + 1'b1 >= {1'b0, count_r});
  assign sts.copy_last = ({1'b0, idx_r} + 1'b1 >= {1'b0, n_r}) || (n_r == '0);
  assign sts.changes   = chg;
  assign sts.fits      = ((n_r + NW'(p0)) <= NW'(CAPACITY));

  logic [NW-1:0] n1;
  assign n1 = n_r + 1'b1;

  always_ff @(posedge clk) begin
    if (p0 && n_r < NW'(CAPACITY)) begin
      ws_mem[n_r[IW-1:0]] <= p0s; we_mem[n_r[IW-1:0]] <= p0e;
    end
    if (p1 && n1 < NW'(CAPACITY)) begin
      ws_mem[n1[IW-1:0]] <= p1s; we_mem[n1[IW-1:0]] <= p1e;
    end
    if (cmd.commit && idx_r < NW'(CAPACITY)) begin
      st_mem[idx_r[IW-1:0]] <= ws_mem[idx_r[IW-1:0]];
      en_mem[idx_r[IW-1:0]] <= we_mem[idx_r[IW-1:0]];
    end
  end

  // walk state and result latches
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      idx_r   <= '0;
      n_r     <= '0;
    end else begin
      if (cmd.load) begin
        op_r <= in_operation; l_r <= l_in; r_r <= r_in;
        ml_r <= l_in; mr_r <= r_in; placed_r <= 1'b0;
        idx_r <= '0; n_r <= '0; hit_r <= 1'b0; max_r <= '0; wsum_r <= '0;
        wmax_r <= '0;
      end
      if (cmd.scan) begin
        idx_r <= idx_r + 1'b1;
        ml_r <= ml_nxt; mr_r <= mr_nxt; placed_r <= placed_nxt;
        n_r <= n_r + NW'(p0) + NW'(p1);
        if (p0) wsum_r <= wsum_r + (p0e - p0s) + (p1 ? (p1e - p1s) : '0);
        wmax_r <= wmax_nxt;
        if (in_table) begin
          if (len > max_r) max_r <= len;
          if (op_r == dis_pkg::OP_CONTAINS && a <= l_r && l_r < b) hit_r <= 1'b1;
          if (op_r == dis_pkg::OP_INTERSECT && !empty_rng && a < r_r && b > l_r)
            hit_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        idx_r <= '0;
        n_r <= n_r + NW'(p0);
        if (p0) wsum_r <= wsum_r + (p0e - p0s);
        wmax_r <= wmax_nxt;
      end
      if (cmd.commit) begin
        idx_r <= idx_r + 1'b1;
        if (sts.copy_last) begin
          count_r <= n_r; sum_r <= wsum_r; max_r <= wmax_r;
        end
      end
      if (cmd.done) ovf_r <= chg && !sts.fits;
    end
  end

  assign res_hit   = hit_r;
  assign res_total = 33'(sum_r);
  assign res_max   = 33'(max_r);
  assign res_count = 5'(count_r);
  assign res_ovf   = ovf_r;

endmodule

/* rtl/core/disjoint_interval_set_top.sv */
// One beat in flight: walk the table (S_SCAN), place a pending add range (S_FINISH),
// copy the work table when an add or remove commits (S_COPY), latch the result
// (S_DONE) and hold the result beat (S_OUT); the next beat is taken after the result beat.
// The walk over the table and the commit copy handle one entry per cycle each.
// Reset (rst_n low, synchronous) empties the table; no clearing pass.
// ----------------------------------------------------------------------------
// disjoint_interval_set_top
// Sorted disjoint interval table with add, remove, contains and intersects.
// ----------------------------------------------------------------------------
module disjoint_interval_set_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // operation[1:0], left[33:2], right[66:34]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [79:0]  out_tdata   // hit[0], total_covered[33:1], max_length[66:34],
                                   // interval_count[71:67], overflow[72]
);

  dis_pkg::dis_cmd_t cmd;
  dis_pkg::dis_sts_t sts;
  logic idle, out_busy;
  logic hit, ovf;
  logic [32:0] tot, mx;
  logic [4:0] cnt;

  assign in_tready  = idle;
  assign out_tvalid = out_busy;

  // controller
  dis_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire  (in_tvalid && in_tready),
    .out_fire (out_tvalid && out_tready),
    .sts, .cmd, .idle, .out_busy
  );

  // datapath
  dis_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_operation (in_tdata[1:0]),
    .in_left      (in_tdata[33:2]),
    .in_right     (in_tdata[66:34]),
    .res_hit (hit), .res_total (tot), .res_max (mx), .res_count (cnt), .res_ovf (ovf)
  );

  assign out_tdata = {7'd0, ovf, cnt, mx, tot, hit};

endmodule
